[src/sme_pkg.sv]
// Shared constants and codes for the stack machine evaluator.
package sme_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_W = 32;
   localparam int OP_W = 3;
   localparam int STATUS_W = 3;
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   localparam logic [DATA_W-1:0] INVALID_TOKEN_CODE = DATA_W'(100);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DUMP = 3'd4,
      OP_FAIL = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_TOKEN = 3'd1,
      ST_FAIL      = 3'd2,
      ST_UNKNOWN   = 3'd3,
      ST_UNDERFLOW = 3'd4,
      ST_OVERFLOW  = 3'd5,
      ST_HALTED    = 3'd6
   } status_type;

endpackage

[src/sme_stack_ram.sv]
// Operand stack storage: one write port, two registered read ports.
module sme_stack_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

[src/stack_machine_evaluator_core.sv]
// Stack machine evaluator top level: sequencer, stack RAM and result register.
// Acceptance registers the request and the stack RAM read; the execute and
// write-back state then loads the response register, holding while that register
// is full and rsp_stall holds. No new request is accepted until execute is left.
// Reset clears the entry count, the halted flag and all handshake state; the
// stack RAM contents stay undefined until pushed.
module stack_machine_evaluator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sme_pkg::OP_W-1:0]           req_operation,
   input  logic signed [sme_pkg::DATA_W-1:0]  req_operand,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_dump_valid,
   output logic signed [sme_pkg::DATA_W-1:0]  rsp_dump_value,
   output logic [sme_pkg::STATUS_W-1:0]       rsp_status
);
   import sme_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                halted_ff, halted_in;
   logic [OP_W-1:0]     op_ff;
   logic [DATA_W-1:0]   operand_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_dump_valid_ff, rsp_dump_valid_in;
   logic [DATA_W-1:0]   rsp_dump_value_ff, rsp_dump_value_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic                req_accept;
   logic                rsp_take;
   logic                rsp_free;
   logic [CNT_W-1:0]    count_m1;
   logic [CNT_W-1:0]    count_m2;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic [DATA_W-1:0]   top_data;
   logic [DATA_W-1:0]   below_data;
   logic [DATA_W-1:0]   alu_result;

   // Accept one request at a time; the response register is separate, so a
   // new request may come in while the previous response waits.
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign count_m1 = count_ff - CNT_W'(1);
   assign count_m2 = count_ff - CNT_W'(2);

   // Read the top two entries at accept; the count does not move until the
   // execute cycle, and the previous write-back has already landed by then, so
   // the reads never race a pending write.
   sme_stack_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (DATA_W),
      .ADDR_W(ADDR_W)
   ) u_stack_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (req_accept),
      .rd_addr_a(count_m1[ADDR_W-1:0]),
      .rd_addr_b(count_m2[ADDR_W-1:0]),
      .rd_data_a(top_data),
      .rd_data_b(below_data)
   );

   // Arithmetic on the registered RAM outputs; all ops wrap modulo 2^32.
   always_comb begin
      case (op_type'(op_ff))
         OP_ADD:  alu_result = below_data + top_data;
         OP_SUB:  alu_result = below_data - top_data;
         default: alu_result = below_data * top_data;
      endcase
   end

   // Execute: decide status, stack update and response together.
   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      halted_in         = halted_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_take;
      rsp_dump_valid_in = rsp_dump_valid_ff;
      rsp_dump_value_in = rsp_dump_value_ff;
      rsp_status_in     = rsp_status_ff;
      wr_en             = 1'b0;
      wr_addr           = count_ff[ADDR_W-1:0];
      wr_data           = operand_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // Hold in execute until the response register can take a result.
            if (rsp_free) begin
               state_in          = S_IDLE;
               rsp_valid_in      = 1'b1;
               rsp_dump_valid_in = 1'b0;
               rsp_dump_value_in = '0;
               rsp_status_in     = ST_OK;
               if (halted_ff) begin
                  rsp_status_in = ST_HALTED;
               end else begin
                  unique case (op_type'(op_ff)) inside
                     OP_PUSH: begin
                        if (count_ff == CNT_W'(STACK_DEPTH)) begin
                           rsp_status_in = ST_OVERFLOW;
                           halted_in     = 1'b1;
                        end else begin
                           wr_en    = 1'b1;
                           wr_addr  = count_ff[ADDR_W-1:0];
                           wr_data  = operand_ff;
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                     OP_ADD, OP_SUB, OP_MUL: begin
                        if (count_ff < CNT_W'(2)) begin
                           rsp_status_in = ST_UNDERFLOW;
                           halted_in     = 1'b1;
                        end else begin
                           // Replace the second entry, drop the top.
                           wr_en    = 1'b1;
                           wr_addr  = count_m2[ADDR_W-1:0];
                           wr_data  = alu_result;
                           count_in = count_m1;
                        end
                     end
                     OP_DUMP: begin
                        if (count_ff == '0) begin
                           rsp_status_in = ST_UNDERFLOW;
                           halted_in     = 1'b1;
                        end else begin
                           rsp_dump_valid_in = 1'b1;
                           rsp_dump_value_in = top_data;
                           count_in          = count_m1;
                        end
                     end
                     OP_FAIL: begin
                        rsp_status_in = (operand_ff == INVALID_TOKEN_CODE) ?
                                        ST_BAD_TOKEN : ST_FAIL;
                        halted_in     = 1'b1;
                     end
                     default: begin
                        rsp_status_in = ST_UNKNOWN;
                        halted_in     = 1'b1;
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // Payload registers carry no reset.
      if (req_accept) begin
         op_ff      <= req_operation;
         operand_ff <= req_operand;
      end
      rsp_dump_valid_ff <= rsp_dump_valid_in;
      rsp_dump_value_ff <= rsp_dump_value_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dump_valid = rsp_dump_valid_ff;
   assign rsp_dump_value = rsp_dump_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the stack machine evaluator core.
`timescale 1ns / 1ps

module testbench;
   import sme_pkg::*;

   // Opcodes that the block does not decode; it must halt with the unknown status.
   localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

   localparam int RANDOM_ITEMS = 2000;
   localparam int HALTED_ITEMS = 30;
   localparam int HOLD_START = 300;     // accepted transactions before the long hold
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_LIMIT = 2000;   // cycles to wait for outstanding responses
   localparam int SETTLE_CYCLES = 8;    // leave a margin for stray responses
   localparam int MAX_PRINTS = 50;

   typedef struct {
      logic [OP_W-1:0]   opcode;
      logic [DATA_W-1:0] operand;
   } instr_type;

   typedef struct packed {
      logic              dump_valid;
      logic [DATA_W-1:0] dump_value;
      status_type        status;
   } rsp_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OP_W-1:0]           req_operation = '0;
   logic signed [DATA_W-1:0]  req_operand = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_dump_valid;
   logic signed [DATA_W-1:0]  rsp_dump_value;
   logic [STATUS_W-1:0]       rsp_status;

   stack_machine_evaluator_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_operand    (req_operand),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_dump_valid (rsp_dump_valid),
      .rsp_dump_value (rsp_dump_value),
      .rsp_status     (rsp_status)
   );

   // 8 ns period: high half, then low half.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow machine: our own copy of the operand stack, its depth and the
   // halt latch. Advanced once per accepted transaction, in accept order.
   // ---------------------------------------------------------------------
   logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
   int                shadow_depth = 0;
   bit                shadow_halted = 1'b0;

   rsp_type           expected_rsps [$];
   instr_type         pending_instrs [$];

   int                mismatch_count = 0;
   int                accepted_count = 0;
   int                total_items = 1;
   int                gen_depth = 0;      // stack depth as seen by the generator
   int                send_idle_pct;
   int                recv_idle_pct;
   int                hold_left = 0;
   bit                hold_done = 1'b0;

   // Execute one instruction on the shadow machine and return its response.
   function automatic rsp_type execute_instruction(logic [OP_W-1:0] opcode,
                                                   logic [DATA_W-1:0] imm);
      rsp_type           r;
      logic [DATA_W-1:0] top;
      logic [DATA_W-1:0] below;
      r = '{dump_valid: 1'b0, dump_value: '0, status: ST_OK};
      // A halted machine answers everything with the halted status and keeps its state.
      if (shadow_halted) begin
         r.status = ST_HALTED;
         return r;
      end
      case (opcode) inside
         OP_PUSH: begin
            if (shadow_depth >= STACK_DEPTH) begin
               r.status = ST_OVERFLOW;
            end else begin
               shadow_stack[shadow_depth] = imm;
               shadow_depth++;
            end
         end
         OP_ADD, OP_SUB, OP_MUL: begin
            if (shadow_depth < 2) begin
               r.status = ST_UNDERFLOW;
            end else begin
               top = shadow_stack[shadow_depth - 1];
               below = shadow_stack[shadow_depth - 2];
               // Subtract is second minus top; all three wrap at 32 bits.
               if (opcode == OP_ADD)
                  shadow_stack[shadow_depth - 2] = below + top;
               else if (opcode == OP_SUB)
                  shadow_stack[shadow_depth - 2] = below - top;
               else
                  shadow_stack[shadow_depth - 2] = below * top;
               shadow_depth--;
            end
         end
         OP_DUMP: begin
            if (shadow_depth == 0) begin
               r.status = ST_UNDERFLOW;
            end else begin
               shadow_depth--;
               r.dump_valid = 1'b1;
               r.dump_value = shadow_stack[shadow_depth];
            end
         end
         OP_FAIL: r.status = (imm == INVALID_TOKEN_CODE) ? ST_BAD_TOKEN : ST_FAIL;
         default: r.status = ST_UNKNOWN;
      endcase
      // Every fault status latches the halt.
      if (r.status != ST_OK)
         shadow_halted = 1'b1;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTS)
         $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic add_instr(input logic [OP_W-1:0] opcode, input logic [DATA_W-1:0] value);
      instr_type it;
      it.opcode = opcode;
      it.operand = value;
      pending_instrs.push_back(it);
      case (opcode) inside
         OP_PUSH: gen_depth++;
         OP_ADD, OP_SUB, OP_MUL, OP_DUMP: gen_depth--;
         default: ;
      endcase
   endtask

   // Lean on the corners: both extremes, all ones, small values, then anything.
   function automatic logic [DATA_W-1:0] random_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'($urandom_range(0, 16));
         4: return -32'($urandom_range(1, 16));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [OP_W-1:0] random_arith();
      case ($urandom_range(0, 2))
         0: return OP_ADD;
         1: return OP_SUB;
         default: return OP_MUL;
      endcase
   endfunction

   // Pick an instruction that keeps the stack legal at the generator's depth.
   task automatic add_legal_instr(input bit no_push);
      int roll;
      roll = $urandom_range(0, 99);
      if (gen_depth == 0 && !no_push)
         add_instr(OP_PUSH, random_operand());
      else if (gen_depth >= STACK_DEPTH || no_push) begin
         if (gen_depth >= 2 && roll < 50)
            add_instr(random_arith(), random_operand());
         else
            add_instr(OP_DUMP, random_operand());
      end else if (roll < 45)
         add_instr(OP_PUSH, random_operand());
      else if (roll < 75 && gen_depth >= 2)
         add_instr(random_arith(), random_operand());
      else
         add_instr(OP_DUMP, random_operand());
   endtask

   // ---------------------------------------------------------------------
   // Idle rates by phase of the run: receiver-heavy idling first, then the
   // receiver idles less than the sender, then a stretch at full rate.
   // ---------------------------------------------------------------------
   always_comb begin
      case ((accepted_count * 3) / total_items)
         0: begin
            send_idle_pct = 29;
            recv_idle_pct = 48;
         end
         1: begin
            send_idle_pct = 48;
            recv_idle_pct = 29;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   end

   // Long receiver hold-off, counted here: fire once, partway through the first phase,
   // so the core backs up and has to stall its request side.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_START) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver: stall at random, or solidly while the long hold runs.
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
   end

   // ---------------------------------------------------------------------
   // Driver: log each accepted transaction into the shadow machine, then
   // present the next pending instruction unless we choose to idle. Hold the
   // payload steady while the core stalls.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : driver
      instr_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(execute_instruction(req_operation, req_operand));
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pending_instrs.pop_front();
               req_valid <= 1'b1;
               req_operation <= nxt.opcode;
               req_operand <= nxt.operand;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare every accepted response against the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch($sformatf("unexpected response status=%0d dump_valid=%0b",
                                      rsp_status, rsp_dump_valid));
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
            if (rsp_dump_valid !== want.dump_valid)
               report_mismatch($sformatf("dump_valid got %0b want %0b",
                                         rsp_dump_valid, want.dump_valid));
            if (rsp_dump_value !== want.dump_value)
               report_mismatch($sformatf("dump_value got %08h want %08h",
                                         rsp_dump_value, want.dump_value));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence: build the instruction stream, release reset, wait for
   // everything to drain, then give the verdict.
   // ---------------------------------------------------------------------
   initial begin : main_seq
      int directed_count;
      int fault_kind;
      int walk_len;
      int waited;
      logic [DATA_W-1:0] fail_code;

      // Directed: wrap-around on each arithmetic op at the extremes, then dump.
      add_instr(OP_PUSH, 32'h7fff_ffff);
      add_instr(OP_PUSH, 32'h0000_0001);
      add_instr(OP_ADD, 32'h0);            // max + 1 wraps to min
      add_instr(OP_DUMP, 32'hffff_ffff);
      add_instr(OP_PUSH, 32'h8000_0000);
      add_instr(OP_PUSH, 32'h0000_0001);
      add_instr(OP_SUB, 32'h0);            // min - 1 wraps to max
      add_instr(OP_DUMP, 32'h0);
      add_instr(OP_PUSH, 32'hffff_ffff);
      add_instr(OP_PUSH, 32'h8000_0000);
      add_instr(OP_MUL, 32'h0);            // -1 * min stays min
      add_instr(OP_DUMP, 32'h0);
      // Operand order matters for subtract; the invalid-token code as plain data.
      add_instr(OP_PUSH, 32'h1234_5678);
      add_instr(OP_PUSH, 32'hedcb_a987);
      add_instr(OP_MUL, 32'h0);
      add_instr(OP_PUSH, INVALID_TOKEN_CODE);
      add_instr(OP_SUB, 32'h0);
      add_instr(OP_DUMP, 32'h0);
      add_instr(OP_PUSH, 32'h0);
      add_instr(OP_DUMP, 32'h0);
      directed_count = pending_instrs.size();

      // Random: legal instruction walks, with an occasional fill to a full
      // stack and a pop all the way back down.
      while (pending_instrs.size() < directed_count + RANDOM_ITEMS) begin
         if ($urandom_range(0, 15) == 0) begin
            while (gen_depth < STACK_DEPTH)
               add_instr(OP_PUSH, random_operand());
            while (gen_depth > 0)
               add_legal_instr(1'b1);
         end else begin
            walk_len = $urandom_range(8, 40);
            repeat (walk_len)
               add_legal_instr(1'b0);
         end
      end

      // One halting fault per run (reset comes only once); the seed picks which.
      fault_kind = $urandom_range(0, 6);
      case (fault_kind)
         0: begin   // push on a full stack
            while (gen_depth < STACK_DEPTH)
               add_instr(OP_PUSH, random_operand());
            add_instr(OP_PUSH, random_operand());
         end
         1: begin   // arithmetic with fewer than two entries
            while (gen_depth > $urandom_range(0, 1))
               add_instr(OP_DUMP, random_operand());
            add_instr(random_arith(), random_operand());
         end
         2: begin   // dump on an empty stack
            while (gen_depth > 0)
               add_instr(OP_DUMP, random_operand());
            add_instr(OP_DUMP, random_operand());
         end
         3: add_instr(OP_FAIL, INVALID_TOKEN_CODE);
         4: begin   // fail with any code other than the invalid token
            fail_code = random_operand();
            if (fail_code == INVALID_TOKEN_CODE)
               fail_code = fail_code + 1;
            add_instr(OP_FAIL, fail_code);
         end
         5: add_instr(OP_UNDEF_LO, random_operand());
         default: add_instr(OP_UNDEF_HI, random_operand());
      endcase

      // Everything after the fault must come back halted, whatever it is.
      repeat (HALTED_ITEMS)
         add_instr(3'($urandom_range(0, 7)), $urandom());

      total_items = pending_instrs.size();

      // Release reset.
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last transaction to be accepted (sampled away from the edge).
      @(negedge clock);
      while (pending_instrs.size() != 0 || req_valid)
         @(negedge clock);

      // Drain outstanding responses, then give strays time to show up.
      waited = 0;
      while (expected_rsps.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[filelist.f]
src/sme_pkg.sv
src/sme_stack_ram.sv
src/stack_machine_evaluator_core.sv
tb/testbench.sv
